FILE: hdl/md5_pkg.sv
// Shared types, constants and round tables for the MD5 digest block.
package md5_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_READ  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_OUT   = 6'b100000
  } md5_state_t;

  // Initial chaining values.
  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  // Padding marker byte and the byte position where the length field starts.
  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [1:0] LAST_LANE = 2'd3;
  localparam logic [1:0] LAST_WORD = 2'd3;

  // Additive constant of each round.
  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left rotate amount of each round, by group and position within the group.
  function automatic logic [4:0] round_shift(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'b0000: s = 5'd7;   4'b0001: s = 5'd12;
      4'b0010: s = 5'd17;  4'b0011: s = 5'd22;
      4'b0100: s = 5'd5;   4'b0101: s = 5'd9;
      4'b0110: s = 5'd14;  4'b0111: s = 5'd20;
      4'b1000: s = 5'd4;   4'b1001: s = 5'd11;
      4'b1010: s = 5'd16;  4'b1011: s = 5'd23;
      4'b1100: s = 5'd6;   4'b1101: s = 5'd10;
      4'b1110: s = 5'd15;  4'b1111: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by each round, modulo the sixteen words of a block.
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] i;
    unique case (r[5:4])
      2'd0:    i = r[3:0];
      2'd1:    i = 4'((r[3:0] << 2) + r[3:0] + 4'd1);
      2'd2:    i = 4'((r[3:0] << 1) + r[3:0] + 4'd5);
      2'd3:    i = 4'((r[3:0] << 3) - r[3:0]);
      default: i = 4'd0;
    endcase
    return i;
  endfunction

  // Left rotate of a 32-bit word.
  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

endpackage

FILE: hdl/md5_ram.sv
// Generic single write port, single read port RAM with a registered read.
module md5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/md5_message_digest.sv
// Top level of the MD5 digest engine over a byte stream.
//
// Input channel (s_*): one word per message byte. s_tdata carries the byte,
// s_tuser says whether the byte is present and s_tlast ends the message.
// Output channel (m_*): four digest words per message, word 0 first; the
// little-endian bytes of word i are digest bytes 4i to 4i+3.
// Bytes that do not complete a 64-byte block are taken one per cycle.
// A byte that completes a block is followed by compression: a read
// state, 64 rounds of the single round unit at one round a cycle, and
// an add state that folds the result into the chaining words.
// At end of message the padding bytes are written one per cycle (9 to 72
// of them) with one or two compressions, then the four words are offered.
// s_tready is low during the compression after a block fill, and
// from end of message until the last digest word is taken; a stalled
// receiver simply holds the block in that state.
// Reset (rst, synchronous) loads the initial chaining words and clears the
// byte position and bit count, leaving the block idle and ready. After the
// last digest word the same state is restored for the next message.
module md5_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_valid
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [1:0]  m_tuser,   // [1:0] word_index
  output logic        m_tlast    // last_word
);

  md5_pkg::md5_state_t state, state_next;

  logic [31:0] chain [4];
  logic [31:0] wa, wb, wc, wd;
  logic [63:0] bit_count;
  logic [5:0]  byte_pos;
  logic [31:0] word_acc;
  logic [5:0]  round;
  logic [1:0]  out_idx;
  logic        pad_active;
  logic        pad_first;
  logic        len_phase;

  logic        in_fire;
  logic        out_fire;
  logic        put_en;
  logic [7:0]  put_byte;
  logic [31:0] acc_next;
  logic        ram_we;
  logic [5:0]  rd_round;
  logic [3:0]  rd_addr;
  logic [31:0] msg_word;
  logic [31:0] f_val;
  logic [31:0] round_sum;
  logic [31:0] b_new;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  assign s_tready = (state == md5_pkg::ST_IDLE);
  assign m_tvalid = (state == md5_pkg::ST_OUT);
  assign m_tdata  = chain[out_idx];
  assign m_tuser  = out_idx;
  assign m_tlast  = (out_idx == md5_pkg::LAST_WORD);

  // Byte source: the message byte while idle, the padding bytes in ST_PAD.
  always_comb begin
    put_en   = 1'b0;
    put_byte = 8'h00;
    if (state == md5_pkg::ST_IDLE) begin
      put_en   = in_fire && s_tuser;
      put_byte = s_tdata;
    end else if (state == md5_pkg::ST_PAD) begin
      put_en = 1'b1;
      if (pad_first) begin
        put_byte = md5_pkg::PAD_MARK;
      end else if (!len_phase && byte_pos != md5_pkg::LEN_START) begin
        put_byte = 8'h00;
      end else begin
        put_byte = bit_count[{byte_pos[2:0], 3'b000} +: 8];
      end
    end
  end

  // Little-endian word assembly; a word goes to the buffer with its last byte.
  always_comb begin
    if (byte_pos[1:0] == 2'd0) begin
      acc_next = {24'h0, put_byte};
    end else begin
      acc_next = word_acc | ({24'h0, put_byte} << {byte_pos[1:0], 3'b000});
    end
  end

  assign ram_we = put_en && (byte_pos[1:0] == md5_pkg::LAST_LANE);

  // Read address runs one round ahead of the round unit.
  assign rd_round = (state == md5_pkg::ST_READ) ? 6'd0 : round + 6'd1;
  assign rd_addr  = md5_pkg::msg_index(rd_round);

  md5_ram #(
    .WIDTH(32),
    .DEPTH(16)
  ) u_block_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_pos[5:2]),
    .wdata (acc_next),
    .raddr (rd_addr),
    .rdata (msg_word)
  );

  // The shared round unit.
  always_comb begin
    unique case (round[5:4])
      2'd0:    f_val = (wb & wc) | (~wb & wd);
      2'd1:    f_val = (wb & wd) | (wc & ~wd);
      2'd2:    f_val = wb ^ wc ^ wd;
      2'd3:    f_val = wc ^ (wb | ~wd);
      default: f_val = 32'h0;
    endcase
    round_sum = wa + f_val + md5_pkg::round_k(round) + msg_word;
    b_new     = wb + md5_pkg::rotl32(round_sum, md5_pkg::round_shift(round));
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      md5_pkg::ST_IDLE: begin
        if (put_en && byte_pos == md5_pkg::LAST_POS) begin
          state_next = md5_pkg::ST_READ;
        end else if (in_fire && s_tlast) begin
          state_next = md5_pkg::ST_PAD;
        end
      end
      md5_pkg::ST_PAD: begin
        if (byte_pos == md5_pkg::LAST_POS) begin
          state_next = md5_pkg::ST_READ;
        end
      end
      md5_pkg::ST_READ: begin
        state_next = md5_pkg::ST_ROUND;
      end
      md5_pkg::ST_ROUND: begin
        if (round == md5_pkg::LAST_ROUND) begin
          state_next = md5_pkg::ST_ADD;
        end
      end
      md5_pkg::ST_ADD: begin
        if (len_phase) begin
          state_next = md5_pkg::ST_OUT;
        end else if (pad_active) begin
          state_next = md5_pkg::ST_PAD;
        end else begin
          state_next = md5_pkg::ST_IDLE;
        end
      end
      md5_pkg::ST_OUT: begin
        if (out_fire && out_idx == md5_pkg::LAST_WORD) begin
          state_next = md5_pkg::ST_IDLE;
        end
      end
      default: state_next = md5_pkg::ST_IDLE;
    endcase
  end

  // Control and chaining state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= md5_pkg::ST_IDLE;
      chain[0]   <= md5_pkg::INIT_A;
      chain[1]   <= md5_pkg::INIT_B;
      chain[2]   <= md5_pkg::INIT_C;
      chain[3]   <= md5_pkg::INIT_D;
      bit_count  <= 64'h0;
      byte_pos   <= 6'd0;
      round      <= 6'd0;
      out_idx    <= 2'd0;
      pad_active <= 1'b0;
      pad_first  <= 1'b0;
      len_phase  <= 1'b0;
    end else begin
      state <= state_next;
      if (put_en) begin
        byte_pos <= byte_pos + 6'd1;
      end
      if (state == md5_pkg::ST_IDLE && in_fire) begin
        if (s_tuser) begin
          bit_count <= bit_count + 64'd8;
        end
        if (s_tlast) begin
          pad_active <= 1'b1;
          pad_first  <= 1'b1;
        end
      end
      if (state == md5_pkg::ST_PAD) begin
        pad_first <= 1'b0;
        if (!pad_first && byte_pos == md5_pkg::LEN_START) begin
          len_phase <= 1'b1;
        end
      end
      if (state == md5_pkg::ST_READ) begin
        round <= 6'd0;
      end else if (state == md5_pkg::ST_ROUND) begin
        round <= round + 6'd1;
      end
      if (state == md5_pkg::ST_ADD) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
      end
      if (out_fire) begin
        if (out_idx == md5_pkg::LAST_WORD) begin
          chain[0]   <= md5_pkg::INIT_A;
          chain[1]   <= md5_pkg::INIT_B;
          chain[2]   <= md5_pkg::INIT_C;
          chain[3]   <= md5_pkg::INIT_D;
          bit_count  <= 64'h0;
          byte_pos   <= 6'd0;
          out_idx    <= 2'd0;
          pad_active <= 1'b0;
          pad_first  <= 1'b0;
          len_phase  <= 1'b0;
        end else begin
          out_idx <= out_idx + 2'd1;
        end
      end
    end
  end

  // Working words and the partial buffer word.
  always_ff @(posedge clk) begin
    if (put_en) begin
      word_acc <= acc_next;
    end
    if (state == md5_pkg::ST_READ) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
    end else if (state == md5_pkg::ST_ROUND) begin
      wa <= wd;
      wb <= b_new;
      wc <= wb;
      wd <= wc;
    end
  end

`ifndef NO_ASSERTIONS
  // The input and output sides are never open at the same time.
  a_sides_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while digest word offered");

  // Compression always runs on a full block, so the position is zero meanwhile.
  a_pos_zero_in_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == md5_pkg::ST_ROUND || state == md5_pkg::ST_ADD) |-> byte_pos == 6'd0)
    else $error("byte position not zero during compression");

  // The final round is followed by the chaining update.
  a_round_to_add: assert property (@(posedge clk) disable iff (rst)
    (state == md5_pkg::ST_ROUND && round == md5_pkg::LAST_ROUND)
      |=> state == md5_pkg::ST_ADD)
    else $error("compression did not end after the last round");

  // Digest words are offered only once the length has been written.
  a_out_after_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (len_phase && pad_active))
    else $error("digest offered before padding finished");

  // Taking the last word restores the start state for the next message.
  a_reinit: assert property (@(posedge clk) disable iff (rst)
    (out_fire && m_tlast) |=> (bit_count == 64'h0 && byte_pos == 6'd0
      && chain[0] == md5_pkg::INIT_A && s_tready))
    else $error("state not restored after digest");
`endif

endmodule

FILE: verif/md5_message_digest_tb.sv
// Self-checking testbench for the MD5 byte-stream digest block.
module md5_message_digest_tb;

  // Idle cycles with no handshake before the run is declared hung.
  localparam int STALL_LIMIT  = 4000;
  // Cycles for which the receiver refuses digest words once, mid-run.
  localparam int HOLD_CYCLES  = 600;
  // Cycles allowed after the last digest word for the block to settle.
  localparam int DRAIN_CYCLES = 200;
  localparam int ITEM_TARGET  = 430;
  localparam int MIN_MESSAGES = 16;

  // Additive constant of each of the 64 rounds.
  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, four per group of sixteen rounds.
  localparam int ROT_AMOUNT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_entry_t;

  // Digest predictor and store of the digest words still to arrive.
  class digest_scoreboard;
    logic [31:0]   chain[4];
    logic [31:0]   block_buf[16];
    logic [63:0]   msg_bits;
    logic [5:0]    fill_pos;
    digest_entry_t digest_words_due[$];
    int unsigned   errors;
    int unsigned   words_checked;

    function new();
      restart();
      errors = 0;
      words_checked = 0;
    endfunction

    function void restart();
      chain[0] = md5_pkg::INIT_A;
      chain[1] = md5_pkg::INIT_B;
      chain[2] = md5_pkg::INIT_C;
      chain[3] = md5_pkg::INIT_D;
      foreach (block_buf[i]) block_buf[i] = '0;
      msg_bits = '0;
      fill_pos = '0;
    endfunction

    // Runs the 64 rounds over the full block and folds them into the chain.
    function void compress_block();
      logic [31:0] a, b, c, d, f, t, sum;
      int grp, idx, s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        grp = r / 16;
        case (grp)
          0: begin
            f = (b & c) | (~b & d);
            idx = r;
          end
          1: begin
            f = (b & d) | (c & ~d);
            idx = 5 * r + 1;
          end
          2: begin
            f = b ^ c ^ d;
            idx = 3 * r + 5;
          end
          default: begin
            f = c ^ (b | ~d);
            idx = 7 * r;
          end
        endcase
        idx = idx % 16;
        s = ROT_AMOUNT[grp * 4 + r % 4];
        sum = a + f + K_TABLE[r] + block_buf[idx];
        t = d;
        d = c;
        c = b;
        b = b + ((sum << s) | (sum >> (32 - s)));
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    // Packs one octet little-endian into the block; a full block compresses.
    function void place_octet(logic [7:0] v);
      logic [3:0] w;
      int sh;
      w = fill_pos[5:2];
      sh = 8 * fill_pos[1:0];
      if (sh == 0) block_buf[w] = '0;
      block_buf[w] |= {24'h0, v} << sh;
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0) compress_block();
    endfunction

    // Takes in one accepted input word; an end mark pads and queues the digest.
    function void note_item(logic [7:0] data, logic present, logic eom);
      logic [63:0] len_bits;
      digest_entry_t e;
      if (present) begin
        place_octet(data);
        msg_bits += 64'd8;
      end
      if (eom) begin
        len_bits = msg_bits;
        place_octet(md5_pkg::PAD_MARK);
        while (fill_pos != md5_pkg::LEN_START) place_octet(8'h00);
        for (int i = 0; i < 8; i++) place_octet(len_bits[8 * i +: 8]);
        for (int i = 0; i < 4; i++) begin
          e.digest_word = chain[i];
          e.word_index = i[1:0];
          e.last_word = (i == 3);
          digest_words_due.push_back(e);
        end
        restart();
      end
    endfunction

    task report_mismatch(string what);
      $display("ERROR: %s", what);
      errors++;
    endtask

    // Compares one accepted digest word with the oldest one due.
    task check_word(logic [31:0] word, logic [1:0] index, logic last);
      digest_entry_t e;
      if (digest_words_due.size() == 0) begin
        report_mismatch($sformatf("digest word %08h with no message finished", word));
      end else begin
        e = digest_words_due.pop_front();
        if (word !== e.digest_word)
          report_mismatch($sformatf("word %0d digest_word: got %08h, want %08h",
                                    words_checked, word, e.digest_word));
        if (index !== e.word_index)
          report_mismatch($sformatf("word %0d word_index: got %0d, want %0d",
                                    words_checked, index, e.word_index));
        if (last !== e.last_word)
          report_mismatch($sformatf("word %0d last_word: got %0b, want %0b",
                                    words_checked, last, e.last_word));
      end
      words_checked++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  digest_scoreboard sb = new();
  int items_sent = 0;
  int messages_sent = 0;
  int idle_cycles = 0;

  md5_message_digest u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none at all in a burst.
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one input word from a falling edge and returns at the falling
  // edge after it has been taken.
  task automatic send_item(logic [7:0] data, logic present, logic eom, bit burst);
    int gap;
    gap = pick_gap(burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= present;
    s_tlast  <= eom;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Sends a message of len bytes with occasional empty words in between;
  // the end mark rides on the last byte or follows in a word of its own.
  task automatic send_message(int len, bit burst);
    bit end_on_byte;
    end_on_byte = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if (!burst && $urandom_range(0, 9) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, burst);
      send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1),
                burst);
    end
    if (!end_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, burst);
    messages_sent++;
  endtask

  // Input and output monitors feed the scoreboard at the rising edge.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_item(s_tdata, s_tuser, s_tlast);
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser, m_tlast);
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: runs of ready broken by gaps, and one long hold-off that
  // backs the block up into its input once a few digests have come out.
  initial begin : receiver
    int on_len;
    int off_len;
    bit held;
    m_tready = 1'b0;
    held = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) on_len = $urandom_range(50, 150);
      else on_len = $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (on_len) @(negedge clk);
      if (!held && sb.words_checked >= 8) begin
        off_len = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        off_len = pick_gap(1'b0);
      end
      if (off_len > 0) begin
        m_tready <= 1'b0;
        repeat (off_len) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int r;
    int len;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Empty message: end mark with no byte at all.
    send_item(8'hA5, 1'b0, 1'b1, 1'b1);
    // An empty word changes nothing.
    send_item(8'h3C, 1'b0, 1'b0, 1'b1);
    // A single zero byte together with the end mark.
    send_item(8'h00, 1'b1, 1'b1, 1'b1);
    // All-ones byte, an empty word, then the end mark on its own.
    send_item(8'hFF, 1'b1, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0, 1'b0);
    send_item(8'hC3, 1'b0, 1'b1, 1'b0);
    // The familiar three-letter message.
    send_item(8'h61, 1'b1, 1'b0, 1'b1);
    send_item(8'h62, 1'b1, 1'b0, 1'b1);
    send_item(8'h63, 1'b1, 1'b1, 1'b1);
    // Padding marker value as message data.
    send_item(8'h80, 1'b1, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b1, 1'b0);

    // Random messages, mostly short, some near one and two block lengths.
    while (items_sent < ITEM_TARGET || messages_sent < MIN_MESSAGES) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(0, 16);
      else if (r < 90) len = $urandom_range(52, 68);
      else len = $urandom_range(112, 132);
      send_message(len, $urandom_range(0, 3) == 0);
    end
    s_tvalid <= 1'b0;

    while (sb.digest_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/md5_pkg.sv
hdl/md5_ram.sv
hdl/md5_message_digest.sv
verif/md5_message_digest_tb.sv
